// ===== sv/wav_header_parser_assert.svh =====
// assertion macros for the wav header parser
`ifndef WAV_HEADER_PARSER_ASSERT_SVH
`define WAV_HEADER_PARSER_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define WHP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define WHP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define WHP_ASSERT_IMP(lbl, ante, cons, msg)
`define WHP_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// ===== sv/whp_pkg.sv =====
package whp_pkg;

  localparam int unsigned HDR_LEN  = 36;
  localparam int unsigned FMT_BASE = 16;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_beat_t;

  typedef struct packed {
    logic        status;
    logic [15:0] channels;
    logic [31:0] smp_rate;
    logic [15:0] smp_bits;
    logic [31:0] chunk_len;
    logic [31:0] riff_len;
    logic [15:0] fmt_code;
    logic [31:0] bytes_per_sec;
    logic [15:0] frame_len;
    logic [31:0] audio_start;
  } out_beat_t;

  typedef enum logic [2:0] {
    PH_HDR,
    PH_SKIP,
    PH_ID,
    PH_SIZE,
    PH_DONE
  } phase_t;

  typedef enum logic [3:0] {
    SL_NONE,
    SL_FILE_SIZE,
    SL_FMT_SIZE,
    SL_AUDIO_FMT,
    SL_CHANNELS,
    SL_RATE,
    SL_BYTE_RATE,
    SL_ALIGN,
    SL_BITS
  } slot_t;

  localparam logic STATUS_FOUND   = 1'b0;
  localparam logic STATUS_MISSING = 1'b1;

  // which header field a byte of the fixed header lands in
  function automatic slot_t hdr_slot(input logic [5:0] pos);
    slot_t s;
    s = SL_NONE;
    unique case (pos) inside
      [6'd4 : 6'd7]:   s = SL_FILE_SIZE;
      [6'd16 : 6'd19]: s = SL_FMT_SIZE;
      [6'd20 : 6'd21]: s = SL_AUDIO_FMT;
      [6'd22 : 6'd23]: s = SL_CHANNELS;
      [6'd24 : 6'd27]: s = SL_RATE;
      [6'd28 : 6'd31]: s = SL_BYTE_RATE;
      [6'd32 : 6'd33]: s = SL_ALIGN;
      [6'd34 : 6'd35]: s = SL_BITS;
      default:         s = SL_NONE;
    endcase
    return s;
  endfunction

endpackage

// ===== sv/wav_header_parser.sv =====
// RIFF/WAV header parser.
// Input channel: one file byte per beat (in_data.data_byte), with
// in_data.last_byte set on the final byte of the buffer. The parser picks the
// fmt fields out of the fixed 36-byte header, skips extra fmt bytes, then walks
// chunks until a "data" chunk header completes.
// Output channel: at most one result beat per buffer. status 0 carries the fmt
// fields, the data chunk size and the offset of the first audio byte; status 1
// (all other fields zero) means the buffer ended without a data chunk.
// Bytes after a success are dropped until the last byte, which restarts parsing.
// Result path: a byte is taken into the input register, and its result beat is
// loaded into the result register and offered from there; a held result stalls
// the step between the two registers.
// Throughput: one byte per cycle while no result beat is held by out_stall.
// Reset (rst_n low, synchronous) empties both registers and returns the parser
// to the start of the fixed header.
// When out_stall holds a pending result, the input register still takes one
// byte if it is empty; in_stall is then high until the result beat is taken.
module wav_header_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  whp_pkg::in_beat_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output whp_pkg::out_beat_t  out_data
);
  import whp_pkg::*;

  logic      s_valid_r;
  in_beat_t  s_data_r;
  logic      out_valid_r;
  out_beat_t out_data_r;

  logic      adv;
  logic      step_en;
  logic      res_valid;
  out_beat_t res;
  phase_t    phase;
  logic [32:0] skip_left;

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = s_valid_r && !adv;
  assign step_en  = s_valid_r && adv;

  whp_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (step_en),
    .beat      (s_data_r),
    .res_valid (res_valid),
    .res       (res),
    .phase     (phase),
    .skip_left (skip_left)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (!in_stall) begin
        s_valid_r <= in_valid;
      end
      if (adv) begin
        out_valid_r <= s_valid_r && res_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s_data_r <= in_data;
    end
    if (step_en && res_valid) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`include "wav_header_parser_assert.svh"

  `WHP_ASSERT_IMP(a_stall_cause, in_stall, out_valid_r && out_stall, "stall without held result")
  `WHP_ASSERT_IMP(a_skip_nonzero, phase == PH_SKIP, skip_left != 33'd0, "empty skip")
  `WHP_ASSERT_NXT(a_result_loaded, step_en && res_valid, out_valid_r, "result beat lost")

endmodule

// ===== sv/whp_parse.sv =====
module whp_parse (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  whp_pkg::in_beat_t   beat,
  output logic                res_valid,
  output whp_pkg::out_beat_t  res,
  output whp_pkg::phase_t     phase,
  output logic [32:0]         skip_left
);
  import whp_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [31:0] pos_r, pos_nxt;
  logic [1:0]  fbc_r, fbc_nxt;
  logic [31:0] asm_r, asm_nxt;
  logic [32:0] skip_r, skip_nxt;
  logic [31:0] fmt_r, fmt_nxt;
  logic [31:0] tag_r, tag_nxt;
  logic [31:0] riff_len_r, riff_len_nxt;
  logic [15:0] afmt_r, afmt_nxt;
  logic [15:0] chan_r, chan_nxt;
  logic [31:0] rate_r, rate_nxt;
  logic [31:0] brate_r, brate_nxt;
  logic [15:0] align_r, align_nxt;
  logic [15:0] bits_r, bits_nxt;

  logic [31:0] asm_new;
  logic [32:0] skip_dec;
  logic [32:0] fmt_extra;
  logic [32:0] chunk_skip;
  logic [7:0]  b;

  assign b          = beat.data_byte;
  assign skip_dec   = skip_r - 33'd1;
  assign fmt_extra  = (fmt_r > 32'(FMT_BASE)) ? {1'b0, fmt_r - 32'(FMT_BASE)} : 33'd0;
  assign chunk_skip = {1'b0, asm_new} + {32'd0, asm_new[0]};

  always_comb begin
    asm_new = asm_r;
    asm_new[{fbc_r, 3'b000} +: 8] = b;
  end

  always_comb begin
    phase_nxt    = phase_r;
    pos_nxt      = pos_r + 32'd1;
    fbc_nxt      = fbc_r;
    asm_nxt      = asm_r;
    skip_nxt     = skip_r;
    fmt_nxt      = fmt_r;
    tag_nxt      = tag_r;
    riff_len_nxt = riff_len_r;
    afmt_nxt     = afmt_r;
    chan_nxt     = chan_r;
    rate_nxt     = rate_r;
    brate_nxt    = brate_r;
    align_nxt    = align_r;
    bits_nxt     = bits_r;
    res_valid    = 1'b0;
    res          = '0;

    unique case (phase_r)
      PH_HDR: begin
        case (hdr_slot(pos_r[5:0]))
          SL_FILE_SIZE: riff_len_nxt[{pos_r[1:0], 3'b000} +: 8] = b;
          SL_FMT_SIZE:  fmt_nxt[{pos_r[1:0], 3'b000} +: 8]      = b;
          SL_AUDIO_FMT: afmt_nxt[{pos_r[0], 3'b000} +: 8]       = b;
          SL_CHANNELS:  chan_nxt[{pos_r[0], 3'b000} +: 8]       = b;
          SL_RATE:      rate_nxt[{pos_r[1:0], 3'b000} +: 8]     = b;
          SL_BYTE_RATE: brate_nxt[{pos_r[1:0], 3'b000} +: 8]    = b;
          SL_ALIGN:     align_nxt[{pos_r[0], 3'b000} +: 8]      = b;
          SL_BITS:      bits_nxt[{pos_r[0], 3'b000} +: 8]       = b;
          default: ;
        endcase
        if (pos_r[5:0] == 6'(HDR_LEN - 1)) begin
          skip_nxt  = fmt_extra;
          fbc_nxt   = 2'd0;
          tag_nxt   = '0;
          asm_nxt   = '0;
          phase_nxt = (fmt_extra == 33'd0) ? PH_ID : PH_SKIP;
        end
      end
      PH_SKIP: begin
        if (skip_r != 33'd0) begin
          skip_nxt = skip_dec;
        end
        if (skip_r == 33'd0 || skip_dec == 33'd0) begin
          skip_nxt  = 33'd0;
          fbc_nxt   = 2'd0;
          tag_nxt   = '0;
          asm_nxt   = '0;
          phase_nxt = PH_ID;
        end
      end
      PH_ID: begin
        tag_nxt[{fbc_r, 3'b000} +: 8] = b;
        if (fbc_r == 2'd3) begin
          fbc_nxt   = 2'd0;
          asm_nxt   = '0;
          phase_nxt = PH_SIZE;
        end else begin
          fbc_nxt = fbc_r + 2'd1;
        end
      end
      PH_SIZE: begin
        asm_nxt = asm_new;
        if (fbc_r != 2'd3) begin
          fbc_nxt = fbc_r + 2'd1;
        end else if (tag_r == TAG_DATA) begin
          res_valid         = 1'b1;
          res.status        = STATUS_FOUND;
          res.channels      = chan_r;
          res.smp_rate      = rate_r;
          res.smp_bits      = bits_r;
          res.chunk_len     = asm_new;
          res.riff_len      = riff_len_r;
          res.fmt_code      = afmt_r;
          res.bytes_per_sec = brate_r;
          res.frame_len     = align_r;
          res.audio_start   = pos_r + 32'd1;
          phase_nxt         = PH_DONE;
        end else begin
          skip_nxt  = chunk_skip;
          fbc_nxt   = 2'd0;
          tag_nxt   = '0;
          asm_nxt   = '0;
          phase_nxt = (chunk_skip == 33'd0) ? PH_ID : PH_SKIP;
        end
      end
      default: ;
    endcase

    if (beat.last_byte) begin
      if (!res_valid && phase_r != PH_DONE) begin
        res_valid  = 1'b1;
        res        = '0;
        res.status = STATUS_MISSING;
      end
      phase_nxt    = PH_HDR;
      pos_nxt      = '0;
      fbc_nxt      = '0;
      asm_nxt      = '0;
      skip_nxt     = '0;
      fmt_nxt      = '0;
      tag_nxt      = '0;
      riff_len_nxt = '0;
      afmt_nxt     = '0;
      chan_nxt     = '0;
      rate_nxt     = '0;
      brate_nxt    = '0;
      align_nxt    = '0;
      bits_nxt     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HDR;
      pos_r      <= '0;
      fbc_r      <= '0;
      asm_r      <= '0;
      skip_r     <= '0;
      fmt_r      <= '0;
      tag_r      <= '0;
      riff_len_r <= '0;
      afmt_r     <= '0;
      chan_r     <= '0;
      rate_r     <= '0;
      brate_r    <= '0;
      align_r    <= '0;
      bits_r     <= '0;
    end else if (en) begin
      phase_r    <= phase_nxt;
      pos_r      <= pos_nxt;
      fbc_r      <= fbc_nxt;
      asm_r      <= asm_nxt;
      skip_r     <= skip_nxt;
      fmt_r      <= fmt_nxt;
      tag_r      <= tag_nxt;
      riff_len_r <= riff_len_nxt;
      afmt_r     <= afmt_nxt;
      chan_r     <= chan_nxt;
      rate_r     <= rate_nxt;
      brate_r    <= brate_nxt;
      align_r    <= align_nxt;
      bits_r     <= bits_nxt;
    end
  end

  assign phase     = phase_r;
  assign skip_left = skip_r;

endmodule

// ===== tb/tb_wav_header_parser.sv =====
`timescale 1ns / 100ps

module tb_wav_header_parser;
  import whp_pkg::*;

  localparam int unsigned LIMIT = 400000;
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;

  localparam int OFS_FILE_SIZE = 4;
  localparam int OFS_FMT_LEN   = 16;
  localparam int OFS_FORMAT    = 20;
  localparam int OFS_CHANNELS  = 22;
  localparam int OFS_RATE      = 24;
  localparam int OFS_BYTE_RATE = 28;
  localparam int OFS_ALIGN     = 32;
  localparam int OFS_BITS      = 34;

  localparam int FILL_RANDOM = 0;
  localparam int FILL_ZERO   = 1;
  localparam int FILL_ONES   = 2;

  typedef enum {RX_FREE, RX_LIGHT, RX_HEAVY, RX_TOGGLE} rx_mode_t;

  typedef struct packed {
    logic     drain_first;
    in_beat_t beat;
  } stim_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_beat_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b1;
  out_beat_t out_data;

  wav_header_parser dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  // parser state mirror
  phase_t      wav_phase = PH_HDR;
  logic [31:0] byte_pos = '0;
  logic [1:0]  lane = '0;
  logic [31:0] size_acc = '0;
  logic [32:0] skip_left = '0;
  logic [31:0] id_acc = '0;
  logic [7:0]  hdr_bytes [0:HDR_LEN-1];
  bit          found = 1'b0;

  out_beat_t   parsed_headers [$];
  stim_t       stim_q [$];
  logic [7:0]  buf_q [$];

  int unsigned useful_bytes = 0;
  int unsigned buffers = 0;
  int unsigned bytes_taken = 0;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;
  int unsigned settle = 0;
  int unsigned hold_left = 0;
  int unsigned hold_mark = 300;
  int unsigned mode_left = 0;
  rx_mode_t    rx_mode = RX_FREE;
  stim_t       next_beat;
  out_beat_t   want;

  function automatic logic [15:0] hdr_le16(input int ofs);
    return {hdr_bytes[ofs+1], hdr_bytes[ofs]};
  endfunction

  function automatic logic [31:0] hdr_le32(input int ofs);
    return {hdr_bytes[ofs+3], hdr_bytes[ofs+2], hdr_bytes[ofs+1], hdr_bytes[ofs]};
  endfunction

  task automatic reset_parse();
    wav_phase = PH_HDR;
    byte_pos  = '0;
    lane      = '0;
    size_acc  = '0;
    skip_left = '0;
    id_acc    = '0;
    found     = 1'b0;
  endtask

  task automatic start_skip(input logic [32:0] n);
    skip_left = n;
    lane      = '0;
    id_acc    = '0;
    size_acc  = '0;
    wav_phase = (n == 33'd0) ? PH_ID : PH_SKIP;
  endtask

  task automatic track_wav_byte(input in_beat_t b);
    out_beat_t   r;
    bit          emit;
    logic [31:0] fmt_len;
    r    = '0;
    emit = 1'b0;
    case (wav_phase)
      PH_HDR: begin
        hdr_bytes[byte_pos] = b.data_byte;
        if (byte_pos >= HDR_LEN - 1) begin
          fmt_len = hdr_le32(OFS_FMT_LEN);
          start_skip(fmt_len > FMT_BASE ? 33'(fmt_len - FMT_BASE) : 33'd0);
        end
      end
      PH_SKIP: begin
        if (skip_left != 0) skip_left = skip_left - 1;
        if (skip_left == 0) start_skip(33'd0);
      end
      PH_ID: begin
        id_acc = id_acc | (32'(b.data_byte) << (8 * lane));
        if (lane == 2'd3) begin
          lane      = '0;
          size_acc  = '0;
          wav_phase = PH_SIZE;
        end else begin
          lane = lane + 2'd1;
        end
      end
      PH_SIZE: begin
        size_acc = size_acc | (32'(b.data_byte) << (8 * lane));
        if (lane != 2'd3) begin
          lane = lane + 2'd1;
        end else if (id_acc == TAG_DATA) begin
          r.status        = STATUS_FOUND;
          r.channels      = hdr_le16(OFS_CHANNELS);
          r.smp_rate      = hdr_le32(OFS_RATE);
          r.smp_bits      = hdr_le16(OFS_BITS);
          r.chunk_len     = size_acc;
          r.riff_len      = hdr_le32(OFS_FILE_SIZE);
          r.fmt_code      = hdr_le16(OFS_FORMAT);
          r.bytes_per_sec = hdr_le32(OFS_BYTE_RATE);
          r.frame_len     = hdr_le16(OFS_ALIGN);
          r.audio_start   = byte_pos + 1;
          emit      = 1'b1;
          found     = 1'b1;
          wav_phase = PH_DONE;
        end else begin
          start_skip({1'b0, size_acc} + 33'(size_acc[0]));
        end
      end
      default: ;
    endcase
    byte_pos = byte_pos + 1;
    if (b.last_byte) begin
      if (!emit && !found) begin
        r        = '0;
        r.status = STATUS_MISSING;
        emit     = 1'b1;
      end
      reset_parse();
    end
    if (emit) parsed_headers.push_back(r);
  endtask

  // stimulus construction
  function automatic logic [7:0] fill_byte(input int fill);
    if (fill == FILL_ZERO) return 8'h00;
    if (fill == FILL_ONES) return 8'hFF;
    return 8'($urandom);
  endfunction

  task automatic put_fill(input int n, input int fill);
    repeat (n) buf_q.push_back(fill_byte(fill));
  endtask

  task automatic put_le(input logic [31:0] v);
    for (int i = 0; i < 4; i++) buf_q.push_back(v[8*i +: 8]);
  endtask

  task automatic flush_buffer(input int ignored, input bit drain);
    stim_t s;
    foreach (buf_q[i]) begin
      s.drain_first    = drain && (i == 0);
      s.beat.data_byte = buf_q[i];
      s.beat.last_byte = (i == buf_q.size() - 1);
      stim_q.push_back(s);
    end
    useful_bytes += buf_q.size() - ignored;
    buffers++;
    buf_q.delete();
  endtask

  task automatic build_wav(input logic [31:0] fmt_len, input int fill, input int n_chunks,
                           input logic [31:0] big_size, input int trail, input int cut,
                           input bit drain);
    logic [31:0] id;
    logic [31:0] len;
    int          ignored;
    ignored = 0;
    buf_q.delete();
    put_le(TAG_RIFF);
    put_fill(4, fill);
    put_le(TAG_WAVE);
    put_le(TAG_FMT);
    put_le(fmt_len);
    put_fill(16, fill);
    if (fmt_len > 32'd80) begin
      put_fill($urandom_range(1, 12), FILL_RANDOM);
    end else begin
      if (fmt_len > FMT_BASE) put_fill(fmt_len - FMT_BASE, fill);
      for (int i = 0; i < n_chunks; i++) begin
        id = $urandom;
        if (id == TAG_DATA) id = ~id;
        len = $urandom_range(0, 12);
        put_le(id);
        put_le(len);
        put_fill(len + len[0], FILL_RANDOM);
      end
      if (big_size != 0) begin
        put_le(TAG_RIFF);
        put_le(big_size);
        put_fill($urandom_range(1, 12), FILL_RANDOM);
      end else begin
        put_le(TAG_DATA);
        put_fill(4, fill);
        put_fill(trail, FILL_RANDOM);
        ignored = trail;
      end
    end
    if (cut > 0 && cut < buf_q.size()) begin
      while (buf_q.size() > cut) buf_q.pop_back();
      ignored = 0;
    end
    flush_buffer(ignored, drain);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
      reset_parse();
    end else begin
      if (in_valid && !in_stall) begin
        track_wav_byte(in_data);
        bytes_taken++;
      end
      if (in_valid || parsed_headers.size() != 0) settle = 0;
      else settle++;
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (stim_q.size() == 0 ||
                     (stim_q[0].drain_first && (parsed_headers.size() != 0 || settle < 4))) begin
          in_valid <= 1'b0;
        end else begin
          next_beat = stim_q.pop_front();
          in_valid <= 1'b1;
          in_data  <= next_beat.beat;
          if (burst_left <= 1) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 16);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] exp_val);
    if (got !== exp_val) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch %s: expected %h got %h", name, exp_val, got);
    end
  endtask

  // monitor and receiver stall pattern
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (parsed_headers.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result beat: status %b offset %h",
                     out_data.status, out_data.audio_start);
        end else begin
          want = parsed_headers.pop_front();
          check_field("status", 32'(out_data.status), 32'(want.status));
          check_field("channels", 32'(out_data.channels), 32'(want.channels));
          check_field("smp_rate", out_data.smp_rate, want.smp_rate);
          check_field("smp_bits", 32'(out_data.smp_bits), 32'(want.smp_bits));
          check_field("chunk_len", out_data.chunk_len, want.chunk_len);
          check_field("riff_len", out_data.riff_len, want.riff_len);
          check_field("fmt_code", 32'(out_data.fmt_code), 32'(want.fmt_code));
          check_field("bytes_per_sec", out_data.bytes_per_sec, want.bytes_per_sec);
          check_field("frame_len", 32'(out_data.frame_len), 32'(want.frame_len));
          check_field("audio_start", out_data.audio_start, want.audio_start);
        end
      end
      if (hold_left == 0 && bytes_taken >= hold_mark) begin
        hold_left = 400;
        hold_mark += 800;
      end
      if (mode_left == 0) begin
        rx_mode   = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(32, 256);
      end else begin
        mode_left--;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (rx_mode)
          RX_FREE:  out_stall <= 1'b0;
          RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
          default:  out_stall <= ~out_stall;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("** wav_header_parser: FAILED **");
      $finish;
    end
  end

  initial begin
    int          r;
    int          k;
    int          fill;
    int          trail;
    bit          drain;
    logic [31:0] fmt_len;
    logic [31:0] big;
    int unsigned wait_left;

    // one-byte and ten-byte buffers
    buf_q.push_back(8'hFF);
    flush_buffer(0, 1'b0);
    put_fill(10, FILL_ZERO);
    flush_buffer(0, 1'b0);
    // data header completes on the last byte
    build_wav(32'd16, FILL_ZERO, 0, 32'd0, 0, 0, 1'b0);
    // bytes after success, extra fmt bytes, sender waits for the block to empty
    build_wav(32'd18, FILL_ONES, 1, 32'd0, 3, 0, 1'b1);
    // chunk skip count reaching 2^32, then an oversized fmt length
    build_wav(32'd16, FILL_RANDOM, 0, 32'hFFFF_FFFF, 0, 0, 1'b0);
    build_wav(32'hFFFF_FFFF, FILL_RANDOM, 0, 32'd0, 0, 0, 1'b0);
    // one byte short of a complete data header
    build_wav(32'd16, FILL_RANDOM, 0, 32'd0, 0, 43, 1'b0);
    build_wav(32'd7, FILL_RANDOM, 1, 32'd0, 0, 0, 1'b0);

    while (useful_bytes < 1500 || buffers < 20) begin
      r     = $urandom_range(0, 19);
      k     = $urandom_range(0, 9);
      drain = ($urandom_range(0, 14) == 0);
      fill  = ($urandom_range(0, 15) == 0) ? $urandom_range(FILL_ZERO, FILL_ONES) : FILL_RANDOM;
      trail = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
      fmt_len = (k < 6) ? 32'd16 : (k < 8) ? 32'd16 + $urandom_range(1, 9)
                                           : 32'($urandom_range(0, 15));
      case ($urandom_range(0, 3))
        0:       big = 32'hFFFF_FFFF;
        1:       big = 32'hFFFF_FFFE;
        2:       big = 32'h8000_0001;
        default: big = $urandom | 32'h100;
      endcase
      if (r <= 12) begin
        build_wav(fmt_len, fill, $urandom_range(0, 3), 32'd0, trail, 0, drain);
      end else if (r <= 14) begin
        build_wav(fmt_len, fill, $urandom_range(0, 3), 32'd0, 0, $urandom_range(1, 60), drain);
      end else if (r <= 16) begin
        put_fill($urandom_range(1, 60), FILL_RANDOM);
        flush_buffer(0, drain);
      end else if (r == 17) begin
        build_wav(fmt_len, fill, $urandom_range(0, 2), big, 0, 0, drain);
      end else if (r == 18) begin
        build_wav($urandom | 32'h100, fill, 0, 32'd0, 0, 0, drain);
      end else begin
        build_wav(fmt_len, fill, 6, 32'd0, trail, 0, drain);
      end
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (stim_q.size() != 0 || in_valid) @(posedge clk);
    wait_left = 20000;
    while (parsed_headers.size() != 0 && wait_left != 0) begin
      @(posedge clk);
      wait_left--;
    end
    repeat (10) @(posedge clk);
    if (parsed_headers.size() != 0) begin
      mismatches += parsed_headers.size();
      $display("%0d expected results never arrived", parsed_headers.size());
    end
    if (mismatches == 0) begin
      $display("** wav_header_parser: PASSED **");
    end else begin
      $display("** wav_header_parser: FAILED **");
    end
    $finish;
  end

endmodule
